>>> hw/rtl/lsps_pkg.sv
package lsps_pkg;

   localparam int SENSOR_W   = 10;
   localparam int GAIN_W     = 4;
   localparam int DUTY_W     = 7;
   localparam int ERR_W      = 6;
   localparam int SUM_W      = 8;
   localparam int CORR_W     = 14;
   localparam int CORR_OUT_W = 12;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 32;

   localparam logic [SENSOR_W-1:0] LINE_HIGH = 10'd1000;
   localparam logic signed [ERR_W-1:0] ERR_LOST = 6'sd25;
   localparam logic signed [ERR_W-1:0] ERR_SIDE = 6'sd10;
   localparam logic signed [CORR_W-1:0] CORR_LIMIT = 14'sd1575;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 4'd3;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 4'd0;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 4'd1;
   localparam logic [DUTY_W-1:0] BASE_DUTY_RST   = 7'd68;
   localparam logic [DUTY_W-1:0] MIN_DUTY_RST    = 7'd55;
   localparam logic [DUTY_W-1:0] MAX_DUTY_RST    = 7'd85;
   localparam logic [DUTY_W-1:0] INTEG_LIMIT_RST = 7'd30;

   typedef enum logic [2:0] {
      REG_PROP_GAIN   = 3'd0,
      REG_INTEG_GAIN  = 3'd1,
      REG_DERIV_GAIN  = 3'd2,
      REG_BASE_DUTY   = 3'd3,
      REG_MIN_DUTY    = 3'd4,
      REG_MAX_DUTY    = 3'd5,
      REG_INTEG_LIMIT = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] deriv_gain;
      logic [DUTY_W-1:0] base_duty;
      logic [DUTY_W-1:0] min_duty;
      logic [DUTY_W-1:0] max_duty;
      logic [DUTY_W-1:0] integ_limit;
   } cfg_type;

endpackage

>>> hw/rtl/line_sensor_pid_steering.sv
// channel   direction  fields (low bit first)
// req       in         tdata: sensor_far_left, sensor_left, sensor_mid,
//                             sensor_right, sensor_far_right (10 b each)
// rsp       out        tdata: left_duty (7), right_duty (7), steer_correction (12 s)
// csr       in/out     APB write/read of seven registers at 4*index
//
// A request moves through an input register and a result register; one request
// per cycle is sustained while the result is not stalled.
// The whole PID step is one pass of logic between those two registers.
// Reset clears both valid flags, the previous error and the integral; the
// registers return to their defaults. A stalled result holds the result
// register, and the input register still takes one request behind it.
module line_sensor_pid_steering (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // sensor_far_left, sensor_left, sensor_mid,
                                   // sensor_right, sensor_far_right, 6 b pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // left_duty, right_duty, steer_correction, 6 b pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lsps_pkg::cfg_type cfg;

   lsps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lsps_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hw/rtl/lsps_csr.sv
module lsps_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lsps_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [lsps_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [lsps_pkg::DATA_W-1:0]     csr_prdata,
   output logic                            csr_pready,
   output lsps_pkg::cfg_type               cfg
);

   lsps_pkg::cfg_type       cfg_ff;
   lsps_pkg::cfg_type       cfg_in;
   lsps_pkg::reg_index_type index;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign index      = lsps_pkg::reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            lsps_pkg::REG_PROP_GAIN:   cfg_in.prop_gain   = csr_pwdata[3:0];
            lsps_pkg::REG_INTEG_GAIN:  cfg_in.integ_gain  = csr_pwdata[3:0];
            lsps_pkg::REG_DERIV_GAIN:  cfg_in.deriv_gain  = csr_pwdata[3:0];
            lsps_pkg::REG_BASE_DUTY:   cfg_in.base_duty   = csr_pwdata[6:0];
            lsps_pkg::REG_MIN_DUTY:    cfg_in.min_duty    = csr_pwdata[6:0];
            lsps_pkg::REG_MAX_DUTY:    cfg_in.max_duty    = csr_pwdata[6:0];
            lsps_pkg::REG_INTEG_LIMIT: cfg_in.integ_limit = csr_pwdata[6:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         lsps_pkg::REG_PROP_GAIN:   csr_prdata = {28'd0, cfg_ff.prop_gain};
         lsps_pkg::REG_INTEG_GAIN:  csr_prdata = {28'd0, cfg_ff.integ_gain};
         lsps_pkg::REG_DERIV_GAIN:  csr_prdata = {28'd0, cfg_ff.deriv_gain};
         lsps_pkg::REG_BASE_DUTY:   csr_prdata = {25'd0, cfg_ff.base_duty};
         lsps_pkg::REG_MIN_DUTY:    csr_prdata = {25'd0, cfg_ff.min_duty};
         lsps_pkg::REG_MAX_DUTY:    csr_prdata = {25'd0, cfg_ff.max_duty};
         lsps_pkg::REG_INTEG_LIMIT: csr_prdata = {25'd0, cfg_ff.integ_limit};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain   <= lsps_pkg::PROP_GAIN_RST;
         cfg_ff.integ_gain  <= lsps_pkg::INTEG_GAIN_RST;
         cfg_ff.deriv_gain  <= lsps_pkg::DERIV_GAIN_RST;
         cfg_ff.base_duty   <= lsps_pkg::BASE_DUTY_RST;
         cfg_ff.min_duty    <= lsps_pkg::MIN_DUTY_RST;
         cfg_ff.max_duty    <= lsps_pkg::MAX_DUTY_RST;
         cfg_ff.integ_limit <= lsps_pkg::INTEG_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/lsps_core.sv
module lsps_core (
   input  logic                                clock,
   input  logic                                reset,
   input  lsps_pkg::cfg_type                   cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lsps_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lsps_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // input register
   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [lsps_pkg::SENSOR_W-1:0]     s0_ff, s1_ff, s2_ff, s3_ff, s4_ff;

   // loop state
   logic signed [lsps_pkg::ERR_W-1:0] last_error_ff;
   logic signed [lsps_pkg::ERR_W-1:0] last_error_in;
   logic signed [lsps_pkg::SUM_W-1:0] error_sum_ff;
   logic signed [lsps_pkg::SUM_W-1:0] error_sum_in;

   // result register
   logic                                  out_valid_ff;
   logic                                  out_valid_in;
   logic [lsps_pkg::DUTY_W-1:0]           left_ff, left_in;
   logic [lsps_pkg::DUTY_W-1:0]           right_ff, right_in;
   logic signed [lsps_pkg::CORR_OUT_W-1:0] corr_ff, corr_in;

   logic                               accept;
   logic                               advance;
   logic                               fire;
   logic signed [lsps_pkg::ERR_W-1:0]  err;
   logic signed [8:0]                  sum_raw;
   logic signed [8:0]                  lim_pos;
   logic signed [8:0]                  lim_neg;
   logic signed [8:0]                  sum_sat;
   logic signed [6:0]                  diff;
   logic signed [10:0]                 p_term;
   logic signed [11:0]                 i_term;
   logic signed [10:0]                 d_term;
   logic signed [lsps_pkg::CORR_W-1:0] corr;
   logic signed [lsps_pkg::CORR_W-1:0] left_raw;
   logic signed [lsps_pkg::CORR_W-1:0] right_raw;
   logic signed [lsps_pkg::CORR_W-1:0] min_ext;
   logic signed [lsps_pkg::CORR_W-1:0] max_ext;
   logic signed [lsps_pkg::CORR_W-1:0] base_ext;

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   always_comb begin
      priority if (s0_ff == '0 && s1_ff == '0 && s2_ff == '0 && s3_ff == '0 && s4_ff == '0)
         err = (last_error_ff > 0) ? lsps_pkg::ERR_LOST : -lsps_pkg::ERR_LOST;
      else if (s1_ff == '0 && s3_ff == lsps_pkg::LINE_HIGH)
         err = lsps_pkg::ERR_SIDE;
      else if (s1_ff == lsps_pkg::LINE_HIGH && s3_ff == '0)
         err = -lsps_pkg::ERR_SIDE;
      else
         err = '0;
   end

   // saturate the integral
   always_comb begin
      sum_raw = {error_sum_ff[7], error_sum_ff} + {{3{err[5]}}, err};
      lim_pos = {2'b00, cfg.integ_limit};
      lim_neg = -lim_pos;
      priority if (sum_raw > lim_pos)
         sum_sat = lim_pos;
      else if (sum_raw < lim_neg)
         sum_sat = lim_neg;
      else
         sum_sat = sum_raw;
   end

   assign error_sum_in = fire ? sum_sat[7:0] : error_sum_ff;
   assign last_error_in = fire ? err : last_error_ff;
   assign diff = {err[5], err} - {last_error_ff[5], last_error_ff};

   assign p_term = $signed({7'd0, cfg.prop_gain}) * $signed({{5{err[5]}}, err});
   assign i_term = $signed({8'd0, cfg.integ_gain})
                 * $signed({{4{sum_sat[7]}}, sum_sat[7:0]});
   assign d_term = $signed({7'd0, cfg.deriv_gain}) * $signed({{4{diff[6]}}, diff});

   assign corr = {{3{p_term[10]}}, p_term} + {{2{i_term[11]}}, i_term}
               + {{3{d_term[10]}}, d_term};

   assign base_ext  = {7'd0, cfg.base_duty};
   assign min_ext   = {7'd0, cfg.min_duty};
   assign max_ext   = {7'd0, cfg.max_duty};
   assign left_raw  = base_ext - corr;
   assign right_raw = base_ext + corr;

   always_comb begin
      priority if (left_raw > max_ext)
         left_in = cfg.max_duty;
      else if (left_raw < min_ext)
         left_in = cfg.min_duty;
      else
         left_in = left_raw[6:0];
   end

   always_comb begin
      priority if (right_raw > max_ext)
         right_in = cfg.max_duty;
      else if (right_raw < min_ext)
         right_in = cfg.min_duty;
      else
         right_in = right_raw[6:0];
   end

   always_comb begin
      priority if (corr > lsps_pkg::CORR_LIMIT)
         corr_in = lsps_pkg::CORR_LIMIT[11:0];
      else if (corr < -lsps_pkg::CORR_LIMIT)
         corr_in = 12'(-lsps_pkg::CORR_LIMIT);
      else
         corr_in = corr[11:0];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, corr_ff, right_ff, left_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_ff <= req_tdata[9:0];
         s1_ff <= req_tdata[19:10];
         s2_ff <= req_tdata[29:20];
         s3_ff <= req_tdata[39:30];
         s4_ff <= req_tdata[49:40];
      end
      if (fire) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         corr_ff  <= corr_in;
      end
   end

endmodule

>>> hw/rtl/lsps_checker.sv
module lsps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_pready
);

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:26] == 6'd0)
      else $error("result padding not zero");

   a_zero_corr_even: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25:14] == 12'd0 |-> rsp_tdata[6:0] == rsp_tdata[13:7])
      else $error("duties differ with zero correction");

   a_pready_high: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind line_sensor_pid_steering lsps_checker u_lsps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
